@@ rtl/core/periodic_timer_missed_cycle_skip_unit_defines.svh @@
// Assertion macros used by the periodic timer top level.
`ifndef PERIODIC_TIMER_MISSED_CYCLE_SKIP_UNIT_DEFINES_SVH
`define PERIODIC_TIMER_MISSED_CYCLE_SKIP_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// A property checked on every rising edge of clk outside reset.
`define PTMS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("periodic timer assertion failed");
// A condition that must never hold on a rising edge of clk outside reset.
`define PTMS_ASSERT_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("periodic timer forbidden condition seen");
`else
`define PTMS_ASSERT(lbl, prop)
`define PTMS_ASSERT_NEVER(lbl, cond)
`endif
`endif

@@ rtl/core/ptms_pkg.sv @@
// Shared types, constants and saturating arithmetic of the periodic timer.
`default_nettype none
package ptms_pkg;

	localparam int unsigned TIME_W      = 64;
	localparam int unsigned PERIOD_W    = 63;
	localparam int unsigned CFG_ADDR_W  = 4;
	localparam int unsigned CFG_DATA_W  = 64;
	localparam int unsigned DIV_BITS    = PERIOD_W;
	localparam int unsigned DIV_CNT_W   = $clog2(DIV_BITS);

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(1000000);
	localparam logic [PERIOD_W-1:0] MAX63        = {PERIOD_W{1'b1}};
	localparam logic signed [TIME_W-1:0] S64_MAX = {1'b0, {(TIME_W-1){1'b1}}};
	localparam logic signed [TIME_W-1:0] S64_MIN = {1'b1, {(TIME_W-1){1'b0}}};

	typedef enum logic [1:0] {
		FUNC_RESTART = 2'd0,
		FUNC_CANCEL  = 2'd1,
		FUNC_CONSUME = 2'd2,
		FUNC_QUERY   = 2'd3
	} func_t;

	typedef enum logic {
		REG_PERIOD = 1'b0
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXEC,
		ST_GRID_CHK,
		ST_DIV,
		ST_GRID_SUB,
		ST_GRID_ADD,
		ST_GRID_CAND,
		ST_GRID_MAX,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic                       fired;
		logic                       due;
		logic                       stopped;
		logic [PERIOD_W-1:0]        remaining;
		logic signed [TIME_W-1:0]   expected_time;
		logic signed [TIME_W-1:0]   elapsed;
		logic                       status;
	} result_t;

	function automatic logic signed [TIME_W-1:0] sat_add(
		input logic signed [TIME_W-1:0] a,
		input logic signed [TIME_W-1:0] b
	);
		logic [TIME_W:0] s;
		s = {a[TIME_W-1], a} + {b[TIME_W-1], b};
		if (s[TIME_W] != s[TIME_W-1]) begin
			return s[TIME_W] ? S64_MIN : S64_MAX;
		end
		return s[TIME_W-1:0];
	endfunction

	function automatic logic signed [TIME_W-1:0] sat_sub(
		input logic signed [TIME_W-1:0] a,
		input logic signed [TIME_W-1:0] b
	);
		logic [TIME_W:0] s;
		s = {a[TIME_W-1], a} - {b[TIME_W-1], b};
		if (s[TIME_W] != s[TIME_W-1]) begin
			return s[TIME_W] ? S64_MIN : S64_MAX;
		end
		return s[TIME_W-1:0];
	endfunction

endpackage
`default_nettype wire

@@ rtl/core/ptms_cfg.sv @@
// APB-style configuration register holding the timer period.
`default_nettype none
module ptms_cfg (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [ptms_pkg::CFG_ADDR_W-1:0]     paddr,
	input  wire logic [ptms_pkg::CFG_DATA_W-1:0]     pwdata,
	output logic      [ptms_pkg::CFG_DATA_W-1:0]     prdata,
	output logic                                     pready,
	output logic      [ptms_pkg::PERIOD_W-1:0]       period
);
	import ptms_pkg::*;

	logic [PERIOD_W-1:0] period_q;
	reg_idx_t            idx;
	logic                wr_en;

	// Registers sit on an eight byte stride; the top address bit is the index.
	assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1]);
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign period = period_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= PERIOD_RESET;
		end else if (wr_en && (idx == REG_PERIOD)) begin
			period_q <= pwdata[PERIOD_W-1:0];
		end
	end

	always_comb begin
		unique case (idx)
			REG_PERIOD: prdata = CFG_DATA_W'(period_q);
			default:    prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

@@ rtl/core/ptms_rem_div.sv @@
// Radix-2 restoring remainder unit that shifts the dividend in one bit per cycle.
`default_nettype none
module ptms_rem_div (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	input  wire logic [ptms_pkg::DIV_BITS-1:0]    dividend,
	input  wire logic [ptms_pkg::DIV_BITS-1:0]    divisor,
	output logic                                  done,
	output logic      [ptms_pkg::DIV_BITS-1:0]    remainder
);
	import ptms_pkg::*;

	logic [DIV_BITS-1:0]  dvd_q;
	logic [DIV_BITS-1:0]  dvs_q;
	logic [DIV_BITS-1:0]  rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 run_q;
	logic                 done_q;
	logic [DIV_BITS:0]    trial;
	logic [DIV_BITS+1:0]  diff;

	// The partial remainder stays below the divisor, so either branch fits.
	assign trial = {rem_q, dvd_q[DIV_BITS-1]};
	assign diff  = {1'b0, trial} - {2'b00, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				if (cnt_q == DIV_CNT_W'(DIV_BITS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			dvd_q <= {dvd_q[DIV_BITS-2:0], 1'b0};
			if (!diff[DIV_BITS+1]) begin
				rem_q <= diff[DIV_BITS-1:0];
			end else begin
				rem_q <= trial[DIV_BITS-1:0];
			end
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule
`default_nettype wire

@@ rtl/core/ptms_core.sv @@
// Operation sequencer and timer state of the periodic timer.
`default_nettype none
module ptms_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                req_valid,
	input  wire logic [1:0]                          func,
	input  wire logic signed [ptms_pkg::TIME_W-1:0]  now,
	input  wire logic [ptms_pkg::PERIOD_W-1:0]       period,
	input  wire logic                                slot_free,
	output logic                                     busy,
	output logic                                     res_valid,
	output ptms_pkg::result_t                        res
);
	import ptms_pkg::*;

	state_t state_q;
	state_t state_d;

	logic signed [TIME_W-1:0]   deadline_q;
	logic signed [TIME_W-1:0]   last_fire_q;
	logic                       halted_q;
	func_t                      func_q;
	logic signed [TIME_W-1:0]   now_q;
	logic                       due_q;
	logic                       fired_q;
	logic signed [TIME_W-1:0]   expected_q;
	logic signed [TIME_W-1:0]   elapsed_q;
	logic                       status_q;
	logic signed [TIME_W-1:0]   nxt_q;
	logic [PERIOD_W-1:0]        dist_q;
	logic [PERIOD_W-1:0]        sum_q;

	logic signed [TIME_W-1:0]   p64;
	logic                       accept;
	logic                       div_start;
	logic                       div_done;
	logic [PERIOD_W-1:0]        div_rem;
	logic signed [TIME_W-1:0]   behind;
	logic [TIME_W-1:0]          grow;
	logic signed [TIME_W-1:0]   rem_s;
	logic                       nxt_ahead;

	assign p64       = {1'b0, period};
	assign accept    = req_valid && !busy;
	assign nxt_ahead = nxt_q > now_q;
	assign behind    = sat_sub(now_q, nxt_q);
	assign grow      = {1'b0, dist_q} + {1'b0, period};
	assign rem_s     = sat_sub(deadline_q, now_q);

	ptms_rem_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (behind[PERIOD_W-1:0]),
		.divisor   (period),
		.done      (div_done),
		.remainder (div_rem)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if ((func_q == FUNC_CONSUME) && due_q && (period != '0)) begin
					state_d = ST_GRID_CHK;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_GRID_CHK:  state_d = nxt_ahead ? ST_FINISH : ST_DIV;
			ST_DIV: begin
				if (div_done) state_d = ST_GRID_SUB;
			end
			ST_GRID_SUB:  state_d = ST_GRID_ADD;
			ST_GRID_ADD:  state_d = ST_GRID_CAND;
			ST_GRID_CAND: state_d = ST_GRID_MAX;
			ST_GRID_MAX:  state_d = ST_FINISH;
			ST_FINISH: begin
				if (slot_free) state_d = ST_IDLE;
			end
			default:      state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy      = (state_q != ST_IDLE);
		div_start = (state_q == ST_GRID_CHK) && !nxt_ahead;
		res_valid = (state_q == ST_FINISH) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Architectural timer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadline_q  <= '0;
			last_fire_q <= '0;
			halted_q    <= 1'b1;
		end else begin
			unique case (state_q)
				ST_EXEC: begin
					unique case (func_q)
						FUNC_RESTART: begin
							halted_q    <= 1'b0;
							last_fire_q <= now_q;
							deadline_q  <= sat_add(now_q, p64);
						end
						FUNC_CANCEL: halted_q <= 1'b1;
						FUNC_CONSUME: begin
							if (due_q) begin
								last_fire_q <= now_q;
								if (period == '0) deadline_q <= now_q;
							end
						end
						default: ;
					endcase
				end
				ST_GRID_CHK: begin
					if (nxt_ahead) deadline_q <= nxt_q;
				end
				ST_GRID_MAX: deadline_q <= nxt_ahead ? nxt_q : now_q;
				default: ;
			endcase
		end
	end

	// Per-transaction working registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q     <= func_t'(func);
			now_q      <= now;
			due_q      <= !halted_q && (now >= deadline_q);
			fired_q    <= 1'b0;
			expected_q <= '0;
			elapsed_q  <= '0;
			status_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_EXEC: begin
					if ((func_q == FUNC_CONSUME) && due_q) begin
						fired_q    <= 1'b1;
						expected_q <= deadline_q;
						elapsed_q  <= sat_sub(now_q, last_fire_q);
						nxt_q      <= sat_add(deadline_q, p64);
					end
					if (func_q == FUNC_QUERY) status_q <= halted_q;
				end
				// The next grid point after now is now - (behind mod period) + period,
				// with the added period saturating like the final sum.
				ST_GRID_CHK:  dist_q <= behind[PERIOD_W-1:0];
				ST_GRID_SUB:  dist_q <= dist_q - div_rem;
				ST_GRID_ADD:  sum_q  <= grow[TIME_W-1] ? MAX63 : grow[PERIOD_W-1:0];
				ST_GRID_CAND: nxt_q  <= sat_add(nxt_q, {1'b0, sum_q});
				default: ;
			endcase
		end
	end

	always_comb begin
		res.fired         = fired_q;
		res.due           = due_q;
		res.stopped       = halted_q;
		res.expected_time = expected_q;
		res.elapsed       = elapsed_q;
		res.status        = status_q;
		if (halted_q || rem_s[TIME_W-1]) begin
			res.remaining = '0;
		end else begin
			res.remaining = rem_s[PERIOD_W-1:0];
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/periodic_timer_missed_cycle_skip_unit.sv @@
// Top level of the periodic deadline timer with missed-period skipping.
//
// Usage: each request transaction carries an operation code (restart, cancel,
// consume, query) and the current signed 64-bit time in nanoseconds. Every
// request produces exactly one response transaction with the fire flag, the
// due flag, the stopped flag, the clamped remaining time, the expected fire
// time, the elapsed time since the previous fire and a status bit.
// The timer period is set through the APB-style port at byte address 0
// (64-bit data); it should only be written while no request is in flight.
// Sequence: restart, cancel, query, a consume that does not fire and a firing
// consume at zero period pass through the execute and finish states; a firing
// consume that lands on the next grid point adds a grid check. A consume that
// skips missed periods runs the bit-serial remainder unit, one dividend bit
// per cycle, then the grid subtract, add, candidate and maximum steps. One
// request is in work at a time.
// Reset: the period returns to 1000000 ns, deadline and last fire time to
// zero, and the timer is stopped until the first restart.
// A stalled response waits in the output register; the next request is
// still accepted and worked on, and it holds in its final step until the
// output register is free.
`default_nettype none
`include "periodic_timer_missed_cycle_skip_unit_defines.svh"
module periodic_timer_missed_cycle_skip_unit (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [ptms_pkg::CFG_ADDR_W-1:0]     paddr,
	input  wire logic [ptms_pkg::CFG_DATA_W-1:0]     pwdata,
	output logic      [ptms_pkg::CFG_DATA_W-1:0]     prdata,
	output logic                                     pready,
	input  wire logic                                req_valid,
	output logic                                     req_stall,
	input  wire logic [1:0]                          func,
	input  wire logic signed [ptms_pkg::TIME_W-1:0]  now,
	output logic                                     rsp_valid,
	input  wire logic                                rsp_stall,
	output logic                                     fired,
	output logic                                     due,
	output logic                                     stopped,
	output logic      [ptms_pkg::PERIOD_W-1:0]       remaining,
	output logic signed [ptms_pkg::TIME_W-1:0]       expected_time,
	output logic signed [ptms_pkg::TIME_W-1:0]       elapsed,
	output logic                                     status
);
	import ptms_pkg::*;

	logic [PERIOD_W-1:0] period;
	logic                busy;
	logic                res_valid;
	logic                slot_free;
	result_t             res;
	result_t             rsp_q;
	logic                rsp_valid_q;

	ptms_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.period  (period)
	);

	ptms_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.func      (func),
		.now       (now),
		.period    (period),
		.slot_free (slot_free),
		.busy      (busy),
		.res_valid (res_valid),
		.res       (res)
	);

	// The output register is free when empty or when its transaction leaves now.
	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign req_stall = busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign fired         = rsp_q.fired;
	assign due           = rsp_q.due;
	assign stopped       = rsp_q.stopped;
	assign remaining     = rsp_q.remaining;
	assign expected_time = rsp_q.expected_time;
	assign elapsed       = rsp_q.elapsed;
	assign status        = rsp_q.status;

	// An accepted request keeps the sequencer busy for at least the next cycle.
	`PTMS_ASSERT(a_busy_after_accept, (req_valid && !req_stall) |=> req_stall)
	// A timer can only fire when it was due.
	`PTMS_ASSERT_NEVER(a_fire_needs_due, rsp_valid && fired && !due)
	// A stopped timer reports no remaining time.
	`PTMS_ASSERT(a_stopped_no_remaining, (rsp_valid && stopped) |-> (remaining == '0))
	// The stopped status only comes with a stopped timer.
	`PTMS_ASSERT_NEVER(a_status_needs_stop, rsp_valid && status && !stopped)

endmodule
`default_nettype wire
